[rtl/wlsa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlsa_pkg: shared constants for the wear-level slot allocator
// Default geometry, erased byte value and register reset value.
// ----------------------------------------------------------------------------
package wlsa_pkg;

  // Default log size in bytes and highest slot number
  localparam int unsigned LogBytesDef = 4096;
  localparam int unsigned MaxSlotDef  = 255;

  // Value of an erased log byte
  localparam logic [7:0] ERASED_BYTE = 8'hFF;

  // Reset value of the scratch pool base address
  localparam logic [23:0] BASE_RESET = 24'hF01000;

  // Widths of the fixed payload fields
  localparam int unsigned ADDR_W = 24;
  localparam int unsigned POS_W  = 12;
  localparam int unsigned SLOT_W = 8;

endpackage

[rtl/wear_level_slot_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wear_level_slot_allocator: rotating scratch-slot allocator
// Keeps an append-only log of slot numbers and hands out the next slot.
// ----------------------------------------------------------------------------
// After reset the block sweeps the log memory to the erased value, one byte
// per cycle, and holds busy_o high until the sweep is done. A preload stores
// one byte, if its offset lies within the log, and returns its all-zero result
// in the cycle right after the transfer. An allocate scans the log one byte per
// cycle through the single read port of the log memory, the scan ending at the
// first erased byte or at the last byte of the log. When the log is full it is
// swept again one byte per cycle. Each result appears for one cycle with
// result_valid_o high and cannot be held off, so the receiver must take it.
// ----------------------------------------------------------------------------
module wear_level_slot_allocator
  import wlsa_pkg::*;
#(
  parameter int unsigned LOG_BYTES = LogBytesDef,
  parameter int unsigned MAX_SLOT  = MaxSlotDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration
  input  logic              cfg_we_i,
  input  logic [ADDR_W-1:0] cfg_wdata_i,
  // command
  input  logic              start_i,
  output logic              busy_o,
  input  logic              mode_i,
  input  logic [POS_W-1:0]  preload_offset_i,
  input  logic [SLOT_W-1:0] preload_value_i,
  // result
  output logic              result_valid_o,
  output logic [ADDR_W-1:0] slot_addr_o,
  output logic [SLOT_W-1:0] slot_number_o,
  output logic [POS_W-1:0]  log_position_o,
  output logic              log_was_erased_o
);

  localparam int unsigned AW = $clog2(LOG_BYTES);
  localparam logic [AW-1:0] LastIdx = AW'(LOG_BYTES - 1);
  localparam logic [SLOT_W-1:0] MaxSlotVal = SLOT_W'(MAX_SLOT);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCAN,
    ST_CALC,
    ST_ERASE,
    ST_WRITE
  } state_e;

  state_e            state_q;
  logic [AW-1:0]     cnt_q;
  logic              rd_vld_q;
  logic [AW-1:0]     rd_idx_q;
  logic [SLOT_W-1:0] prev_q;
  logic [SLOT_W-1:0] cur_q;
  logic [SLOT_W-1:0] next_q;
  logic [AW-1:0]     pos_q;
  logic              erase_q;
  logic [ADDR_W-1:0] base_q;

  logic              result_valid_q;
  logic [ADDR_W-1:0] slot_addr_q;
  logic [SLOT_W-1:0] slot_number_q;
  logic [POS_W-1:0]  log_position_q;
  logic              log_was_erased_q;

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [SLOT_W-1:0] wr_data;
  logic [SLOT_W-1:0] rd_data;
  logic              accept;
  logic              preload_in_range;
  logic [SLOT_W-1:0] slot_m1;
  logic [ADDR_W-1:0] slot_offset;

  assign accept = start_i && (state_q == ST_IDLE);
  assign busy_o = (state_q != ST_IDLE);
  assign preload_in_range = ({20'd0, preload_offset_i} < 32'(LOG_BYTES));

  // Slot address offset: (slot - 1) * 4096
  assign slot_m1     = next_q - SLOT_W'(1);
  assign slot_offset = {4'd0, slot_m1, 12'd0};

  // Select the log write
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cnt_q;
    wr_data = ERASED_BYTE;
    case (state_q)
      ST_INIT: begin
        wr_en = 1'b1;
      end
      ST_IDLE: begin
        wr_en   = accept && mode_i && preload_in_range;
        wr_addr = AW'(preload_offset_i);
        wr_data = preload_value_i;
      end
      ST_ERASE: begin
        wr_en   = 1'b1;
        wr_data = (cnt_q == '0) ? next_q : ERASED_BYTE;
      end
      ST_WRITE: begin
        wr_en   = 1'b1;
        wr_addr = pos_q;
        wr_data = next_q;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  wlsa_log_ram #(
    .LOG_BYTES(LOG_BYTES)
  ) u_log_ram (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_addr_i(cnt_q),
    .rd_data_o(rd_data)
  );

  // Hold the pool base address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= BASE_RESET;
    end else if (cfg_we_i) begin
      base_q <= cfg_wdata_i;
    end
  end

  // Sequence clear, preload reply, scan, next-slot choice, erase and append
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= ST_INIT;
      cnt_q            <= '0;
      rd_vld_q         <= 1'b0;
      rd_idx_q         <= '0;
      prev_q           <= '0;
      cur_q            <= '0;
      next_q           <= '0;
      pos_q            <= '0;
      erase_q          <= 1'b0;
      result_valid_q   <= 1'b0;
      slot_addr_q      <= '0;
      slot_number_q    <= '0;
      log_position_q   <= '0;
      log_was_erased_q <= 1'b0;
    end else begin
      result_valid_q <= 1'b0;
      rd_vld_q       <= 1'b0;
      case (state_q)
        ST_INIT: begin
          cnt_q <= cnt_q + AW'(1);
          if (cnt_q == LastIdx) begin
            cnt_q   <= '0;
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            cnt_q <= '0;
            if (mode_i) begin
              result_valid_q   <= 1'b1;
              slot_addr_q      <= '0;
              slot_number_q    <= '0;
              log_position_q   <= '0;
              log_was_erased_q <= 1'b0;
            end else begin
              erase_q <= 1'b0;
              prev_q  <= '0;
              state_q <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          // issue the next read, check the byte that came back
          cnt_q    <= cnt_q + AW'(1);
          rd_vld_q <= 1'b1;
          rd_idx_q <= cnt_q;
          if (rd_vld_q) begin
            prev_q <= rd_data;
            if (rd_data == ERASED_BYTE) begin
              pos_q   <= rd_idx_q;
              cur_q   <= (rd_idx_q == '0) ? '0 : prev_q;
              state_q <= ST_CALC;
            end else if (rd_idx_q == LastIdx) begin
              pos_q   <= '0;
              cur_q   <= rd_data;
              erase_q <= 1'b1;
              state_q <= ST_CALC;
            end
          end
        end
        ST_CALC: begin
          next_q <= ((cur_q == '0) || (cur_q >= MaxSlotVal)) ? SLOT_W'(1)
                                                              : cur_q + SLOT_W'(1);
          cnt_q  <= '0;
          state_q <= erase_q ? ST_ERASE : ST_WRITE;
        end
        ST_ERASE: begin
          cnt_q <= cnt_q + AW'(1);
          if (cnt_q == LastIdx) begin
            state_q <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          // ERASE has already placed the slot at offset 0; rewriting it is harmless
          result_valid_q   <= 1'b1;
          slot_addr_q      <= base_q + slot_offset;
          slot_number_q    <= next_q;
          log_position_q   <= POS_W'(pos_q);
          log_was_erased_q <= erase_q;
          cnt_q            <= '0;
          state_q          <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign result_valid_o   = result_valid_q;
  assign slot_addr_o      = slot_addr_q;
  assign slot_number_o    = slot_number_q;
  assign log_position_o   = log_position_q;
  assign log_was_erased_o = log_was_erased_q;

endmodule

[rtl/wlsa_log_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlsa_log_ram: slot log byte store
// Simple dual-port memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module wlsa_log_ram
  import wlsa_pkg::*;
#(
  parameter int unsigned LOG_BYTES = LogBytesDef,
  localparam int unsigned AW = $clog2(LOG_BYTES)
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [AW-1:0]     wr_addr_i,
  input  logic [SLOT_W-1:0] wr_data_i,
  input  logic [AW-1:0]     rd_addr_i,
  output logic [SLOT_W-1:0] rd_data_o
);

  logic [SLOT_W-1:0] mem [LOG_BYTES];

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rd_data_o <= mem[rd_addr_i];
  end

endmodule
